FILE: rtl/core/instruction_decode_timing_assert.svh
// ----------------------------------------------------------------------------
// Instruction decode timing assertion macros
// Shared concurrent assertion forms for the decoder, clocked on clk and
// disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef INSTRUCTION_DECODE_TIMING_ASSERT_SVH
`define INSTRUCTION_DECODE_TIMING_ASSERT_SVH

// Same-cycle implication.
`define IDT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("instruction decode timing: same-cycle check failed");

// Next-cycle implication.
`define IDT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("instruction decode timing: next-cycle check failed");

`endif

FILE: rtl/core/idt_pkg.sv
// ----------------------------------------------------------------------------
// Instruction decode timing package
// Field widths, instruction classes, addressing mode codes and the mode
// decode helpers shared by the decoder and its channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package idt_pkg;

  localparam int unsigned ADDR_W = 16;
  localparam int unsigned WORD_W = 16;

  localparam logic [1:0] KIND_INVALID = 2'd0;
  localparam logic [1:0] KIND_FMT1    = 2'd1;
  localparam logic [1:0] KIND_FMT2    = 2'd2;
  localparam logic [1:0] KIND_JUMP    = 2'd3;

  localparam logic [3:0] MODE_REG  = 4'd0;
  localparam logic [3:0] MODE_IDX  = 4'd1;
  localparam logic [3:0] MODE_SYM  = 4'd2;
  localparam logic [3:0] MODE_ABS  = 4'd3;
  localparam logic [3:0] MODE_IND  = 4'd4;
  localparam logic [3:0] MODE_AINC = 4'd5;
  localparam logic [3:0] MODE_IMM  = 4'd6;
  localparam logic [3:0] MODE_C0   = 4'd7;
  localparam logic [3:0] MODE_C1   = 4'd8;
  localparam logic [3:0] MODE_C2   = 4'd9;
  localparam logic [3:0] MODE_C4   = 4'd10;
  localparam logic [3:0] MODE_C8   = 4'd11;
  localparam logic [3:0] MODE_CN1  = 4'd12;

  localparam logic [1:0] AS_REG  = 2'd0;
  localparam logic [1:0] AS_IDX  = 2'd1;
  localparam logic [1:0] AS_IND  = 2'd2;
  localparam logic [1:0] AS_AINC = 2'd3;

  localparam logic [3:0] REG_PC = 4'd0;
  localparam logic [3:0] REG_SP = 4'd1;
  localparam logic [3:0] REG_SR = 4'd2;
  localparam logic [3:0] REG_CG = 4'd3;

  localparam logic [3:0] OP_MOV  = 4'd4;
  localparam logic [3:0] OP_DADD = 4'd10;

  localparam logic [2:0] F2_PUSH    = 3'd4;
  localparam logic [2:0] F2_CALL    = 3'd5;
  localparam logic [2:0] F2_RETI    = 3'd6;
  localparam logic [2:0] F2_INVALID = 3'd7;

  localparam logic [2:0] FLOW_NONE   = 3'b000;
  localparam logic [2:0] FLOW_BRANCH = 3'b001;
  localparam logic [2:0] FLOW_RETURN = 3'b010;
  localparam logic [2:0] FLOW_CALL   = 3'b100;

  function automatic logic [3:0] decode_mode(input logic [1:0] as_bits,
                                             input logic [3:0] r);
    logic [3:0] m;
    m = MODE_REG;
    unique case (as_bits)
      AS_REG: begin
        m = (r == REG_CG) ? MODE_C0 : MODE_REG;
      end
      AS_IDX: begin
        if (r == REG_SR) m = MODE_ABS;
        else if (r == REG_PC) m = MODE_SYM;
        else if (r == REG_CG) m = MODE_C1;
        else m = MODE_IDX;
      end
      AS_IND: begin
        if (r == REG_CG) m = MODE_C2;
        else if (r == REG_SR) m = MODE_C4;
        else m = MODE_IND;
      end
      AS_AINC: begin
        if (r == REG_PC) m = MODE_IMM;
        else if (r == REG_SR) m = MODE_C8;
        else if (r == REG_CG) m = MODE_CN1;
        else m = MODE_AINC;
      end
      default: m = MODE_REG;
    endcase
    return m;
  endfunction

  function automatic logic needs_ext(input logic [3:0] m);
    return (m == MODE_IDX) || (m == MODE_SYM) || (m == MODE_ABS) || (m == MODE_IMM);
  endfunction

  function automatic logic reg_or_const(input logic [3:0] m);
    return (m == MODE_REG) || (m >= MODE_C0);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/idt_in_if.sv
// ----------------------------------------------------------------------------
// Instruction decode timing input channel
// Carries the instruction address and its first word, one per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface idt_in_if import idt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] insn_addr;
  logic [WORD_W-1:0] header_word;

  modport source (output valid, output insn_addr, output header_word, input ready);
  modport sink (input valid, input insn_addr, input header_word, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/idt_out_if.sv
// ----------------------------------------------------------------------------
// Instruction decode timing result channel
// Carries one decoded instruction header per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface idt_out_if import idt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        insn_kind;
  logic [3:0]        op_code;
  logic              byte_op;
  logic [3:0]        src_reg;
  logic [3:0]        src_mode;
  logic [3:0]        dst_reg;
  logic [3:0]        dst_mode;
  logic [1:0]        length_words;
  logic [3:0]        cycle_count;
  logic [2:0]        flow_flags;
  logic [ADDR_W-1:0] jump_target;

  modport source (output valid, output insn_kind, output op_code, output byte_op,
                  output src_reg, output src_mode, output dst_reg, output dst_mode,
                  output length_words, output cycle_count, output flow_flags,
                  output jump_target, input ready);
  modport sink (input valid, input insn_kind, input op_code, input byte_op,
                input src_reg, input src_mode, input dst_reg, input dst_mode,
                input length_words, input cycle_count, input flow_flags,
                input jump_target, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/idt_cfg_if.sv
// ----------------------------------------------------------------------------
// Instruction decode timing configuration channel
// Carries a write of the memory penalty register, one per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface idt_cfg_if import idt_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] rom_penalty;

  modport source (output valid, output rom_penalty, input ready);
  modport sink (input valid, input rom_penalty, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/instruction_decode_timing.sv
// ----------------------------------------------------------------------------
// Instruction decode timing
// Decodes the first word of a 16-bit instruction into its class, registers,
// addressing modes, length, cycle count, flow flags and jump target.
// ----------------------------------------------------------------------------
// The insn_ch channel takes one beat per instruction: its byte address and
// the first instruction word. The result_ch channel returns one beat per
// instruction, in order. The cfg channel writes the memory penalty added by
// the timing table; it is always ready and should be written only while no
// instruction is in flight.
// The decoder is a three-stage pipeline: classification, field and mode
// decode, then timing, flags and jump target into the output register.
// A result passes through the s1, s2 and s3 registers before it appears, and
// one instruction can be accepted every cycle while result_ch takes results.
// Each stage holds its beat while the stage after it is full and stalled,
// so empty stages still fill while result_ch is stalled; insn_ch drops
// ready only when all three stages hold beats and the output is not taken.
// Reset (rst, synchronous) empties the pipeline and clears the penalty.
// ----------------------------------------------------------------------------
`default_nettype none

module instruction_decode_timing import idt_pkg::*; (
  input logic      clk,
  input logic      rst,
  idt_in_if.sink   insn_ch,
  idt_cfg_if.sink  cfg,
  idt_out_if.source result_ch
);

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] word;
  } s1_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [3:0]        op;
    logic              bop;
    logic [3:0]        sreg;
    logic [3:0]        smode;
    logic [3:0]        dreg;
    logic [3:0]        dmode;
    logic [1:0]        len;
    logic              dmem;
    logic              pc_op;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] offs;
  } s2_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [3:0]        op;
    logic              bop;
    logic [3:0]        sreg;
    logic [3:0]        smode;
    logic [3:0]        dreg;
    logic [3:0]        dmode;
    logic [1:0]        len;
    logic [3:0]        cyc;
    logic [2:0]        flags;
    logic [ADDR_W-1:0] tgt;
  } s3_t;

  logic [1:0] rom_penalty;
  logic       v1, v2, v3;
  logic       rdy1, rdy2, rdy3;
  s1_t        s1, s1_next;
  s2_t        s2, s2_next;
  s3_t        s3, s3_next;

  assign rdy3 = !v3 || result_ch.ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign insn_ch.ready = rdy1;
  assign cfg.ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_penalty <= 2'd0;
    end else if (cfg.valid) begin
      rom_penalty <= cfg.rom_penalty;
    end
  end

  always_comb begin
    s1_next      = '0;
    s1_next.addr = insn_ch.insn_addr;
    s1_next.word = insn_ch.header_word;
    if (insn_ch.header_word[15:13] == 3'd1) begin
      s1_next.kind = KIND_JUMP;
    end else if (insn_ch.header_word[15:10] == 6'd4) begin
      s1_next.kind = (insn_ch.header_word[9:7] == F2_INVALID) ? KIND_INVALID : KIND_FMT2;
    end else if (insn_ch.header_word[15:12] >= 4'd4) begin
      s1_next.kind = KIND_FMT1;
    end else begin
      s1_next.kind = KIND_INVALID;
    end
  end

  always_comb begin
    s2_next      = '0;
    s2_next.kind = s1.kind;
    s2_next.addr = s1.addr;
    s2_next.len  = 2'd1;
    case (s1.kind)
      KIND_JUMP: begin
        s2_next.op   = {1'b0, s1.word[12:10]};
        s2_next.offs = {{6{s1.word[9]}}, s1.word[9:0]};
      end
      KIND_FMT2: begin
        s2_next.op    = {1'b0, s1.word[9:7]};
        s2_next.bop   = s1.word[6];
        s2_next.sreg  = s1.word[3:0];
        s2_next.smode = decode_mode(s1.word[5:4], s1.word[3:0]);
        s2_next.len   = needs_ext(s2_next.smode) ? 2'd2 : 2'd1;
        s2_next.pc_op = (s1.word[9:7] == F2_PUSH) || (s1.word[9:7] == F2_CALL);
      end
      KIND_FMT1: begin
        s2_next.op    = s1.word[15:12];
        s2_next.bop   = s1.word[6];
        s2_next.sreg  = s1.word[11:8];
        s2_next.smode = decode_mode(s1.word[5:4], s1.word[11:8]);
        s2_next.dreg  = s1.word[3:0];
        s2_next.dmode = decode_mode({1'b0, s1.word[7]}, s1.word[3:0]);
        s2_next.dmem  = s1.word[7];
        s2_next.len   = 2'd1 + {1'b0, needs_ext(s2_next.smode)}
                        + {1'b0, needs_ext(s2_next.dmode)};
      end
      default: begin
        s2_next.len = 2'd1;
      end
    endcase
  end

  always_comb begin
    logic [3:0] rp;
    logic       rc;
    logic       ext3;
    logic       dpc;
    rp   = {2'b00, rom_penalty};
    rc   = reg_or_const(s2.smode);
    ext3 = (s2.smode == MODE_IDX) || (s2.smode == MODE_SYM) || (s2.smode == MODE_ABS);
    dpc  = (s2.dreg == REG_PC);

    s3_next       = '0;
    s3_next.kind  = s2.kind;
    s3_next.op    = s2.op;
    s3_next.bop   = s2.bop;
    s3_next.sreg  = s2.sreg;
    s3_next.smode = s2.smode;
    s3_next.dreg  = s2.dreg;
    s3_next.dmode = s2.dmode;
    s3_next.len   = s2.len;
    case (s2.kind)
      KIND_JUMP: begin
        s3_next.cyc   = 4'd2;
        s3_next.flags = FLOW_BRANCH;
        s3_next.tgt   = s2.addr + 16'd2 + {s2.offs[14:0], 1'b0};
      end
      KIND_FMT2: begin
        if (rc) begin
          s3_next.cyc = s2.pc_op ? 4'd3 + rp : 4'd1;
        end else if (ext3) begin
          s3_next.cyc = s2.pc_op ? 4'd5 + rp : 4'd4 + rp;
        end else if ((s2.smode == MODE_IND) || (s2.smode == MODE_AINC)) begin
          s3_next.cyc = s2.pc_op ? 4'd4 + rp : 4'd3 + rp;
        end else begin
          s3_next.cyc = s2.pc_op ? 4'd4 + rp : 4'd0;
        end
        if (s2.op[2:0] == F2_CALL) begin
          s3_next.flags = FLOW_BRANCH | FLOW_CALL;
        end else if (s2.op[2:0] == F2_RETI) begin
          s3_next.flags = FLOW_BRANCH;
        end else begin
          s3_next.flags = FLOW_NONE;
        end
      end
      KIND_FMT1: begin
        if (rc) begin
          s3_next.cyc = s2.dmem ? 4'd4 + rp : (dpc ? 4'd2 : 4'd1);
        end else if (ext3) begin
          s3_next.cyc = s2.dmem ? 4'd6 + rp : (dpc ? 4'd4 : 4'd3);
        end else begin
          s3_next.cyc = s2.dmem ? 4'd5 + rp : (dpc ? 4'd3 : 4'd2);
        end
        if (s2.op == OP_DADD) begin
          s3_next.cyc = s3_next.cyc + 4'd1;
        end
        if (dpc && (s2.op == OP_MOV)) begin
          s3_next.flags = FLOW_BRANCH;
          if ((s2.smode == MODE_AINC) && (s2.sreg == REG_SP)) begin
            s3_next.flags = FLOW_BRANCH | FLOW_RETURN;
          end
        end
      end
      default: begin
        s3_next.cyc = 4'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= insn_ch.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && insn_ch.valid) s1 <= s1_next;
    if (rdy2 && v1) s2 <= s2_next;
    if (rdy3 && v2) s3 <= s3_next;
  end

  assign result_ch.valid        = v3;
  assign result_ch.insn_kind    = s3.kind;
  assign result_ch.op_code      = s3.op;
  assign result_ch.byte_op      = s3.bop;
  assign result_ch.src_reg      = s3.sreg;
  assign result_ch.src_mode     = s3.smode;
  assign result_ch.dst_reg      = s3.dreg;
  assign result_ch.dst_mode     = s3.dmode;
  assign result_ch.length_words = s3.len;
  assign result_ch.cycle_count  = s3.cyc;
  assign result_ch.flow_flags   = s3.flags;
  assign result_ch.jump_target  = s3.tgt;

`include "instruction_decode_timing_assert.svh"

  `IDT_ASSERT_NOW(a_full_when_blocked, !insn_ch.ready, v1 && v2 && v3 && !result_ch.ready)
  `IDT_ASSERT_NEXT(a_mid_stage_holds, v2 && !rdy3, v2)
  `IDT_ASSERT_NOW(a_invalid_is_empty, v3 && (s3.kind == KIND_INVALID),
                  (s3.len == 2'd1) && (s3.cyc == 4'd0) && (s3.flags == FLOW_NONE))
  `IDT_ASSERT_NOW(a_target_only_jump, v3 && (s3.kind != KIND_JUMP), s3.tgt == '0)

endmodule

`default_nettype wire

FILE: dv/decode_checker.sv
// ----------------------------------------------------------------------------
// Instruction decode timing checker
// Watches the instruction, configuration and result channels, predicts the
// decode of every accepted instruction word and compares each result beat
// with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module decode_checker import idt_pkg::*; (
  input  logic clk,
  input  logic rst,
  idt_in_if    insn_ch,
  idt_cfg_if   cfg_ch,
  idt_out_if   result_ch,
  output int   fail_count,
  output int   pending_count,
  output int   checked_count
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  op;
    logic        bop;
    logic [3:0]  sreg;
    logic [3:0]  smode;
    logic [3:0]  dreg;
    logic [3:0]  dmode;
    logic [1:0]  len;
    logic [3:0]  cyc;
    logic [2:0]  flags;
    logic [15:0] tgt;
  } header_decode_t;

  header_decode_t header_decodes[$];
  header_decode_t want;
  header_decode_t got;
  logic [1:0]     mem_penalty;

  function automatic logic [3:0] operand_mode(input logic [1:0] as_f, input logic [3:0] rn);
    logic [3:0] m;
    m = MODE_REG;
    case (as_f)
      AS_REG: m = (rn == REG_CG) ? MODE_C0 : MODE_REG;
      AS_IDX: begin
        case (rn)
          REG_PC:  m = MODE_SYM;
          REG_SR:  m = MODE_ABS;
          REG_CG:  m = MODE_C1;
          default: m = MODE_IDX;
        endcase
      end
      AS_IND: begin
        case (rn)
          REG_SR:  m = MODE_C4;
          REG_CG:  m = MODE_C2;
          default: m = MODE_IND;
        endcase
      end
      default: begin
        case (rn)
          REG_PC:  m = MODE_IMM;
          REG_SR:  m = MODE_C8;
          REG_CG:  m = MODE_CN1;
          default: m = MODE_AINC;
        endcase
      end
    endcase
    return m;
  endfunction

  function automatic logic takes_ext_word(input logic [3:0] m);
    return m inside {MODE_IDX, MODE_SYM, MODE_ABS, MODE_IMM};
  endfunction

  function automatic logic is_plain(input logic [3:0] m);
    return (m == MODE_REG) || (m >= MODE_C0);
  endfunction

  function automatic header_decode_t decode_header(input logic [15:0] pc_addr,
                                                   input logic [15:0] w,
                                                   input logic [1:0]  pen);
    header_decode_t d;
    logic [15:0]    offs;
    logic [2:0]     opc2;
    logic [3:0]     ex;
    logic           stack_op;
    logic           to_mem;
    logic           to_pc;
    d = '0;
    d.len = 2'd1;
    ex = {2'b00, pen};
    if (w[15:13] == 3'b001) begin
      offs = {{6{w[9]}}, w[9:0]};
      d.kind = KIND_JUMP;
      d.op = {1'b0, w[12:10]};
      d.cyc = 4'd2;
      d.flags = FLOW_BRANCH;
      d.tgt = pc_addr + 16'd2 + {offs[14:0], 1'b0};
    end else if (w[15:10] == 6'b000100) begin
      opc2 = w[9:7];
      if (opc2 != F2_INVALID) begin
        stack_op = (opc2 == F2_PUSH) || (opc2 == F2_CALL);
        d.kind = KIND_FMT2;
        d.op = {1'b0, opc2};
        d.bop = w[6];
        d.sreg = w[3:0];
        d.smode = operand_mode(w[5:4], w[3:0]);
        d.len = takes_ext_word(d.smode) ? 2'd2 : 2'd1;
        if (is_plain(d.smode)) begin
          d.cyc = stack_op ? 4'd3 + ex : 4'd1;
        end else if (d.smode inside {MODE_IDX, MODE_SYM, MODE_ABS}) begin
          d.cyc = stack_op ? 4'd5 + ex : 4'd4 + ex;
        end else if (d.smode inside {MODE_IND, MODE_AINC}) begin
          d.cyc = stack_op ? 4'd4 + ex : 4'd3 + ex;
        end else begin
          d.cyc = stack_op ? 4'd4 + ex : 4'd0;
        end
        if (opc2 == F2_CALL) begin
          d.flags = FLOW_BRANCH | FLOW_CALL;
        end else if (opc2 == F2_RETI) begin
          d.flags = FLOW_BRANCH;
        end
      end
    end else if (w[15:12] >= 4'd4) begin
      to_mem = w[7];
      to_pc = (w[3:0] == REG_PC);
      d.kind = KIND_FMT1;
      d.op = w[15:12];
      d.bop = w[6];
      d.sreg = w[11:8];
      d.smode = operand_mode(w[5:4], w[11:8]);
      d.dreg = w[3:0];
      d.dmode = operand_mode({1'b0, to_mem}, w[3:0]);
      d.len = 2'd1 + 2'(takes_ext_word(d.smode)) + 2'(takes_ext_word(d.dmode));
      if (is_plain(d.smode)) begin
        d.cyc = to_mem ? 4'd4 + ex : (to_pc ? 4'd2 : 4'd1);
      end else if (d.smode inside {MODE_IDX, MODE_SYM, MODE_ABS}) begin
        d.cyc = to_mem ? 4'd6 + ex : (to_pc ? 4'd4 : 4'd3);
      end else begin
        d.cyc = to_mem ? 4'd5 + ex : (to_pc ? 4'd3 : 4'd2);
      end
      if (d.op == OP_DADD) begin
        d.cyc = d.cyc + 4'd1;
      end
      if (to_pc && d.op == OP_MOV) begin
        d.flags = FLOW_BRANCH;
        if (d.smode == MODE_AINC && d.sreg == REG_SP) begin
          d.flags = d.flags | FLOW_RETURN;
        end
      end
    end
    return d;
  endfunction

  task automatic compare_field(input string field, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      fail_count++;
      $display("%0t: %s expected %0d, got %0d", $time, field, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      header_decodes.delete();
      mem_penalty = 2'd0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        mem_penalty = cfg_ch.rom_penalty;
      end
      if (result_ch.valid && result_ch.ready) begin
        got.kind = result_ch.insn_kind;
        got.op = result_ch.op_code;
        got.bop = result_ch.byte_op;
        got.sreg = result_ch.src_reg;
        got.smode = result_ch.src_mode;
        got.dreg = result_ch.dst_reg;
        got.dmode = result_ch.dst_mode;
        got.len = result_ch.length_words;
        got.cyc = result_ch.cycle_count;
        got.flags = result_ch.flow_flags;
        got.tgt = result_ch.jump_target;
        if (header_decodes.size() == 0) begin
          fail_count++;
          $display("%0t: result beat expected none, got kind %0d op %0d", $time,
                   got.kind, got.op);
        end else begin
          want = header_decodes.pop_front();
          checked_count++;
          compare_field("insn_kind", want.kind, got.kind);
          compare_field("op_code", want.op, got.op);
          compare_field("byte_op", want.bop, got.bop);
          compare_field("src_reg", want.sreg, got.sreg);
          compare_field("src_mode", want.smode, got.smode);
          compare_field("dst_reg", want.dreg, got.dreg);
          compare_field("dst_mode", want.dmode, got.dmode);
          compare_field("length_words", want.len, got.len);
          compare_field("cycle_count", want.cyc, got.cyc);
          compare_field("flow_flags", want.flags, got.flags);
          compare_field("jump_target", want.tgt, got.tgt);
        end
      end
      if (insn_ch.valid && insn_ch.ready) begin
        header_decodes.push_back(decode_header(insn_ch.insn_addr, insn_ch.header_word,
                                               mem_penalty));
      end
    end
    pending_count = header_decodes.size();
  end

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// Instruction decode timing testbench
// Drives corner-case instruction words and weighted random words of every
// class through the decoder under each memory penalty setting, with random
// stalls on both channels, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import idt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int NUM_PHASES = 5;
  localparam int LONG_HOLD = 40;

  localparam logic [31:0] CORNERS [28] = '{
    {16'h0000, 16'h0000}, {16'h1234, 16'h1400}, {16'h1234, 16'h1FFF},
    {16'h0010, 16'h1380}, {16'hFFFF, 16'hFFFF}, {16'h0000, 16'h2000},
    {16'h0000, 16'h3FFF}, {16'hFFFE, 16'h21FF}, {16'h0002, 16'h2200},
    {16'h0100, 16'h1005}, {16'h0102, 16'h1230}, {16'h0104, 16'h12B0},
    {16'h0106, 16'h12A5}, {16'h0108, 16'h1295}, {16'h010A, 16'h1300},
    {16'h010C, 16'h1174}, {16'h010E, 16'h1222}, {16'h0110, 16'h1233},
    {16'h0112, 16'h1030}, {16'h0114, 16'h4130}, {16'h0116, 16'h4500},
    {16'h0118, 16'h4290}, {16'h011A, 16'hA4B5}, {16'h011C, 16'h4393},
    {16'h011E, 16'h4272}, {16'h0120, 16'h4582}, {16'h0122, 16'h1095},
    {16'h0124, 16'h11A2}
  };

  logic clk;
  logic rst;
  int   fail_count;
  int   pending_count;
  int   checked_count;
  int   cycles;
  bit   hold_req;
  bit   sender_gaps;
  bit   quiet_tail;

  idt_in_if  insn_ch ();
  idt_cfg_if cfg_ch ();
  idt_out_if result_ch ();

  instruction_decode_timing u_top (
    .clk       (clk),
    .rst       (rst),
    .insn_ch   (insn_ch),
    .cfg       (cfg_ch),
    .result_ch (result_ch)
  );

  decode_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .insn_ch       (insn_ch),
    .cfg_ch        (cfg_ch),
    .result_ch     (result_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [15:0] random_header();
    logic [15:0] w;
    int          pick;
    w = 16'($urandom);
    if ($urandom_range(0, 1) == 1) begin
      w[3:0] = 4'($urandom_range(0, 3));
      w[11:8] = 4'($urandom_range(0, 3));
    end
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      w[15:12] = 4'($urandom_range(4, 15));
    end else if (pick < 55) begin
      w[15:10] = 6'b000100;
    end else if (pick < 70) begin
      w[15:13] = 3'b001;
    end else if (pick < 75) begin
      w[15:12] = 4'h0;
    end else if (pick < 80) begin
      w[15:10] = {4'h1, 2'($urandom_range(1, 3))};
    end
    return w;
  endfunction

  function automatic logic [15:0] random_addr();
    logic [15:0] a;
    case ($urandom_range(0, 7))
      0:       a = 16'($urandom_range(0, 7));
      1:       a = 16'hFFF8 | 16'($urandom_range(0, 7));
      default: a = 16'($urandom);
    endcase
    return a;
  endfunction

  task automatic send_insn(input logic [15:0] a, input logic [15:0] w);
    insn_ch.valid <= 1'b1;
    insn_ch.insn_addr <= a;
    insn_ch.header_word <= w;
    @(posedge clk);
    while (!insn_ch.ready) @(posedge clk);
    if (sender_gaps && !hold_req && $urandom_range(0, 5) == 0) begin
      insn_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    insn_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic write_penalty(input logic [1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.rom_penalty <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int  stretch;
    bit  calm;
    stretch = 0;
    calm = 1'b0;
    result_ch.ready <= 1'b1;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
        result_ch.ready <= 1'b1;
      end else if (!quiet_tail && !calm && $urandom_range(0, 5) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        result_ch.ready <= 1'b1;
      end
      if (stretch == 0) begin
        calm = ($urandom_range(0, 2) == 0);
        stretch = $urandom_range(20, 120);
      end else begin
        stretch--;
      end
      @(posedge clk);
    end
  end

  initial begin
    logic [1:0] phase_penalty [NUM_PHASES];
    phase_penalty = '{2'd2, 2'd0, 2'd1, 2'd3, 2'($urandom_range(0, 3))};
    rst <= 1'b1;
    insn_ch.valid <= 1'b0;
    insn_ch.insn_addr <= '0;
    insn_ch.header_word <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.rom_penalty <= '0;
    hold_req = 1'b0;
    sender_gaps = 1'b1;
    quiet_tail = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_penalty(2'd3);
    foreach (CORNERS[i]) begin
      send_insn(CORNERS[i][31:16], CORNERS[i][15:0]);
    end
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      write_penalty(phase_penalty[ph]);
      quiet_tail = (ph == NUM_PHASES - 1);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 40 == 0) begin
          sender_gaps = !quiet_tail && ($urandom_range(0, 2) != 0);
        end
        if (ph == 1 && n == 40) begin
          hold_req = 1'b1;
        end
        send_insn(random_addr(), random_header());
      end
    end
    drain_results();
    repeat (8) @(posedge clk);
    $display("Checked %0d decoded headers: corner words of every class, then weighted",
             checked_count);
    $display("random words under memory penalties 0 to 3, with stalls on both channels.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
